FILE: hdl/hopf_pkg.sv
// hopfield engine package: mode codes, register indexes, reset values and clamp helper
`default_nettype none
package hopf_pkg;

  typedef enum logic [1:0] {
    MODE_WR_WEIGHT = 2'd0,
    MODE_WR_STATE  = 2'd1,
    MODE_UPDATE    = 2'd2,
    MODE_RD_WEIGHT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_STEP_SIZE   = 2'd0,
    REG_NOISE_LIMIT = 2'd1
  } reg_idx_t;

  localparam logic [14:0] STEP_SIZE_RST   = 15'd3277;
  localparam logic [14:0] NOISE_LIMIT_RST = 15'd0;

  localparam logic signed [18:0] Q_ONE_POS = 19'sd16384;
  localparam logic signed [18:0] Q_ONE_NEG = -19'sd16384;

  // clamp a widened q2.14 sum to plus or minus one
  function automatic logic signed [15:0] clamp_one(input logic signed [18:0] v);
    logic signed [18:0] c;
    begin
      c = v;
      if (v > Q_ONE_POS) c = Q_ONE_POS;
      if (v < Q_ONE_NEG) c = Q_ONE_NEG;
      clamp_one = c[15:0];
    end
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hopf_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module hopf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/hopfield_async_neuron_update_top.sv
// hopfield engine top level: weight and state rams, sequencer and multiply-accumulate
// sequencing: weight and state writes and weight reads pass through the exec and response
// states before their result is registered; an update walks the weight row one entry a cycle
// and writes the new state back in the finish state; one request at a time: in_stall stays high
// until the last result is registered; the walk rate is set by the single read port of each ram
// reset: synchronous active-low; afterwards a clearing pass zeroes both rams and no request
// is taken until it ends; the step size and noise limit registers return to their reset values
`default_nettype none
module hopfield_async_neuron_update_top #(
  parameter int NEURONS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_mode,
  input  wire logic [5:0]         in_row_index,
  input  wire logic [5:0]         in_col_index,
  input  wire logic signed [15:0] in_value,
  input  wire logic signed [15:0] in_noise,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [5:0]              out_neuron_index,
  output logic signed [15:0]      out_new_state,
  output logic signed [15:0]      out_weight_read,
  output logic                    out_field_positive,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [14:0]        cfg_wdata
);

  localparam int WAW   = $clog2(NEURONS * NEURONS);
  localparam int SAW   = $clog2(NEURONS);
  localparam int CNT_W = $clog2(NEURONS + 2);
  localparam int ACC_W = 32 + $clog2(NEURONS);
  localparam logic [WAW-1:0] CLR_LAST = WAW'(NEURONS * NEURONS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_EXEC, ST_WALK, ST_FIN, ST_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic [WAW-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          rd_idx_r, rd_idx_nxt;
  logic                      rd_v_r, rd_v_nxt;
  logic                      prod_v_r, prod_v_nxt;
  logic signed [31:0]        prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [15:0]        st_row_r, st_row_nxt;
  hopf_pkg::mode_t           mode_r, mode_nxt;
  logic [5:0]                row_r, row_nxt;
  logic [5:0]                col_r, col_nxt;
  logic signed [15:0]        value_r, value_nxt;
  logic signed [15:0]        noise_r, noise_nxt;
  logic [14:0]               step_size_r, step_size_nxt;
  logic [14:0]               noise_limit_r, noise_limit_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [5:0]                out_index_r, out_index_nxt;
  logic signed [15:0]        out_state_r, out_state_nxt;
  logic signed [15:0]        out_wread_r, out_wread_nxt;
  logic                      out_fpos_r, out_fpos_nxt;

  logic                      w_we, w_re, s_we, s_re;
  logic [WAW-1:0]            w_waddr, w_raddr;
  logic [SAW-1:0]            s_waddr, s_raddr;
  logic [15:0]               w_wdata, s_wdata;
  logic signed [15:0]        w_rdata, s_rdata;

  logic                      row_ok, col_ok, issue, out_free, fpos;
  logic [WAW-1:0]            w_addr_exec, w_addr_walk;
  logic signed [15:0]        clamp_val, upd_state;
  logic signed [16:0]        noise_ext, lim_pos, lim_neg, noise_cl;
  logic signed [18:0]        step_ext, upd_sum;

  hopf_ram #(.WIDTH(16), .DEPTH(NEURONS * NEURONS)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  hopf_ram #(.WIDTH(16), .DEPTH(NEURONS)) u_state_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign in_stall           = (state_r != ST_IDLE);
  assign cfg_ready          = 1'b1;
  assign out_valid          = out_valid_r;
  assign out_neuron_index   = out_index_r;
  assign out_new_state      = out_state_r;
  assign out_weight_read    = out_wread_r;
  assign out_field_positive = out_fpos_r;

  assign row_ok      = (32'(row_r) < NEURONS);
  assign col_ok      = (32'(col_r) < NEURONS);
  assign w_addr_exec = WAW'(32'(row_r) * NEURONS + 32'(col_r));
  assign w_addr_walk = WAW'(32'(row_r) * NEURONS + 32'(cnt_r));
  assign issue       = (state_r == ST_WALK) && (32'(cnt_r) < NEURONS);
  assign out_free    = !out_valid_r || !out_stall;

  // update arithmetic
  assign clamp_val = hopf_pkg::clamp_one({{3{value_r[15]}}, value_r});
  assign fpos      = !acc_r[ACC_W-1] && (|acc_r);
  assign noise_ext = {noise_r[15], noise_r};
  assign lim_pos   = signed'({2'b00, noise_limit_r});
  assign lim_neg   = -lim_pos;
  assign step_ext  = signed'({4'b0000, step_size_r});

  always_comb begin
    noise_cl = noise_ext;
    if (noise_ext > lim_pos) noise_cl = lim_pos;
    if (noise_ext < lim_neg) noise_cl = lim_neg;
  end

  assign upd_sum   = {{3{st_row_r[15]}}, st_row_r} + (fpos ? step_ext : -step_ext)
                     + {{2{noise_cl[16]}}, noise_cl};
  assign upd_state = hopf_pkg::clamp_one(upd_sum);

  // ram port control
  always_comb begin
    w_we    = 1'b0;
    w_waddr = w_addr_exec;
    w_wdata = value_r;
    w_re    = 1'b0;
    w_raddr = w_addr_exec;
    s_we    = 1'b0;
    s_waddr = SAW'(row_r);
    s_wdata = clamp_val;
    s_re    = 1'b0;
    s_raddr = SAW'(row_r);
    case (state_r)
      ST_CLEAR: begin
        w_we    = 1'b1;
        w_waddr = clr_cnt_r;
        w_wdata = '0;
        s_we    = (32'(clr_cnt_r) < NEURONS);
        s_waddr = SAW'(clr_cnt_r);
        s_wdata = '0;
      end
      ST_EXEC: begin
        if (row_ok) begin
          case (mode_r)
            hopf_pkg::MODE_WR_WEIGHT: begin
              w_we = col_ok;
              s_re = col_ok;
            end
            hopf_pkg::MODE_WR_STATE: begin
              s_we = 1'b1;
            end
            hopf_pkg::MODE_RD_WEIGHT: begin
              w_re = col_ok;
              s_re = col_ok;
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        w_re    = issue;
        w_raddr = w_addr_walk;
        s_re    = issue;
        s_raddr = SAW'(cnt_r);
      end
      ST_FIN: begin
        s_we    = out_free;
        s_wdata = upd_state;
      end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    cnt_nxt         = cnt_r;
    rd_idx_nxt      = rd_idx_r;
    rd_v_nxt        = 1'b0;
    prod_v_nxt      = 1'b0;
    prod_nxt        = prod_r;
    acc_nxt         = acc_r;
    st_row_nxt      = st_row_r;
    mode_nxt        = mode_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    value_nxt       = value_r;
    noise_nxt       = noise_r;
    step_size_nxt   = step_size_r;
    noise_limit_nxt = noise_limit_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_index_nxt   = out_index_r;
    out_state_nxt   = out_state_r;
    out_wread_nxt   = out_wread_r;
    out_fpos_nxt    = out_fpos_r;

    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hopf_pkg::REG_STEP_SIZE:   step_size_nxt   = cfg_wdata;
        hopf_pkg::REG_NOISE_LIMIT: noise_limit_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          mode_nxt  = hopf_pkg::mode_t'(in_mode);
          row_nxt   = in_row_index;
          col_nxt   = in_col_index;
          value_nxt = in_value;
          noise_nxt = in_noise;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (mode_r == hopf_pkg::MODE_UPDATE && row_ok) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_RESP;
        end
      end
      ST_WALK: begin
        cnt_nxt    = cnt_r + 1'b1;
        rd_v_nxt   = issue;
        rd_idx_nxt = cnt_r;
        prod_v_nxt = rd_v_r;
        prod_nxt   = w_rdata * s_rdata;
        if (prod_v_r) acc_nxt = acc_r + {{(ACC_W-32){prod_r[31]}}, prod_r};
        if (rd_v_r && (32'(rd_idx_r) == 32'(row_r))) st_row_nxt = s_rdata;
        if (32'(cnt_r) == NEURONS + 1) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = row_r;
          out_state_nxt = upd_state;
          out_wread_nxt = '0;
          out_fpos_nxt  = fpos;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = row_r;
          out_state_nxt = '0;
          out_wread_nxt = '0;
          out_fpos_nxt  = 1'b0;
          if (row_ok) begin
            case (mode_r)
              hopf_pkg::MODE_WR_WEIGHT: begin
                if (col_ok) out_state_nxt = s_rdata;
              end
              hopf_pkg::MODE_WR_STATE: begin
                out_state_nxt = clamp_val;
              end
              hopf_pkg::MODE_RD_WEIGHT: begin
                if (col_ok) begin
                  out_state_nxt = s_rdata;
                  out_wread_nxt = w_rdata;
                end
              end
              default: ;
            endcase
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_cnt_r     <= '0;
      rd_v_r        <= 1'b0;
      prod_v_r      <= 1'b0;
      out_valid_r   <= 1'b0;
      step_size_r   <= hopf_pkg::STEP_SIZE_RST;
      noise_limit_r <= hopf_pkg::NOISE_LIMIT_RST;
    end else begin
      state_r       <= state_nxt;
      clr_cnt_r     <= clr_cnt_nxt;
      rd_v_r        <= rd_v_nxt;
      prod_v_r      <= prod_v_nxt;
      out_valid_r   <= out_valid_nxt;
      step_size_r   <= step_size_nxt;
      noise_limit_r <= noise_limit_nxt;
    end
    cnt_r       <= cnt_nxt;
    rd_idx_r    <= rd_idx_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    st_row_r    <= st_row_nxt;
    mode_r      <= mode_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    value_r     <= value_nxt;
    noise_r     <= noise_nxt;
    out_index_r <= out_index_nxt;
    out_state_r <= out_state_nxt;
    out_wread_r <= out_wread_nxt;
    out_fpos_r  <= out_fpos_nxt;
  end

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while another is in flight");

  // no result during the clearing pass
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid_r)
    else $error("result raised during clearing pass");

  // state ram is not written while a row is being summed
  a_no_state_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> !s_we)
    else $error("state write during row walk");

  // products only flow while walking
  a_prod_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    prod_v_r |-> (state_r == ST_WALK))
    else $error("product valid outside row walk");

endmodule
`default_nettype wire

FILE: dv/tb_hopfield_async_neuron_update_top.sv
// testbench for the hopfield engine: random and directed requests checked against a local model
module tb_hopfield_async_neuron_update_top;

  localparam int NEURONS = 64;
  localparam int Q_UNIT = 16384;
  localparam int PHASE_REQUESTS = 215;
  localparam int HOLD_CYCLES = 400;
  localparam longint TIMEOUT_CYCLES = 1000000;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    hopf_pkg::mode_t    mode;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [15:0] value;
    logic signed [15:0] noise;
  } request_t;

  typedef struct packed {
    logic [5:0]         neuron;
    logic signed [15:0] state;
    logic signed [15:0] wread;
    logic               fpos;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [5:0] in_row_index = '0;
  logic [5:0] in_col_index = '0;
  logic signed [15:0] in_value = '0;
  logic signed [15:0] in_noise = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_neuron_index;
  logic signed [15:0] out_new_state;
  logic signed [15:0] out_weight_read;
  logic out_field_positive;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [14:0] cfg_wdata = '0;

  logic signed [15:0] weight_mem [0:NEURONS*NEURONS-1] = '{default: '0};
  logic signed [15:0] state_mem [0:NEURONS-1] = '{default: '0};
  logic [14:0] step_size_q = hopf_pkg::STEP_SIZE_RST;
  logic [14:0] noise_limit_q = hopf_pkg::NOISE_LIMIT_RST;

  request_t requests_pending [$];
  result_t results_due [$];
  request_t offered;
  result_t seen, want;

  int sender_idle_pct = 0;
  int rx_stall_pct = 0;
  logic pressure_go = 1'b0;
  logic holding_off = 1'b0;
  int errors = 0;
  int checked = 0;
  int positive_fields = 0;
  int mode_count [4] = '{default: 0};

  int step_set [5] = '{0, 16384, 32767, 3277, 0};
  int noise_set [5] = '{16384, 0, 32767, 4000, 0};
  int idle_set [5] = '{0, 67, 0, 13, 0};
  int stall_set [5] = '{0, 0, 67, 13, 0};

  hopfield_async_neuron_update_top #(.NEURONS(NEURONS)) i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_row_index       (in_row_index),
    .in_col_index       (in_col_index),
    .in_value           (in_value),
    .in_noise           (in_noise),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_neuron_index   (out_neuron_index),
    .out_new_state      (out_new_state),
    .out_weight_read    (out_weight_read),
    .out_field_positive (out_field_positive),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic signed [15:0] limit_unit(int v);
    if (v > Q_UNIT) return 16'sd16384;
    if (v < -Q_UNIT) return -16'sd16384;
    return 16'(v);
  endfunction

  function automatic result_t predict_neuron_result(request_t r);
    result_t res;
    longint local_field;
    int nz;
    int lim;
    int sum;
    res.neuron = r.row;
    res.wread = '0;
    res.fpos = 1'b0;
    case (r.mode)
      hopf_pkg::MODE_WR_WEIGHT: weight_mem[{r.row, r.col}] = r.value;
      hopf_pkg::MODE_WR_STATE: state_mem[r.row] = limit_unit(int'(r.value));
      hopf_pkg::MODE_UPDATE: begin
        local_field = 0;
        for (int k = 0; k < NEURONS; k++) begin
          local_field += longint'(weight_mem[{r.row, 6'(k)}]) * longint'(state_mem[k]);
        end
        lim = int'(noise_limit_q);
        nz = int'(r.noise);
        if (nz > lim) nz = lim;
        if (nz < -lim) nz = -lim;
        sum = int'(state_mem[r.row]);
        if (local_field > 0) begin
          res.fpos = 1'b1;
          sum += int'(step_size_q);
        end else begin
          sum -= int'(step_size_q);
        end
        state_mem[r.row] = limit_unit(sum + nz);
      end
      default: res.wread = weight_mem[{r.row, r.col}];
    endcase
    res.state = state_mem[r.row];
    return res;
  endfunction

  function automatic logic signed [15:0] random_q();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) begin
      case ($urandom_range(7))
        0: return -16'sd32768;
        1: return 16'sd32767;
        2: return -16'sd16384;
        3: return 16'sd16384;
        4: return -16'sd16385;
        5: return 16'sd16385;
        6: return 16'sd0;
        default: return -16'sd1;
      endcase
    end
    if (roll < 75) return 16'(int'($urandom_range(32768)) - Q_UNIT);
    return 16'($urandom);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) r.mode = hopf_pkg::MODE_WR_WEIGHT;
    else if (roll < 50) r.mode = hopf_pkg::MODE_WR_STATE;
    else if (roll < 85) r.mode = hopf_pkg::MODE_UPDATE;
    else r.mode = hopf_pkg::MODE_RD_WEIGHT;
    // most requests hit a few hot rows so that their weight rows fill up
    r.row = ($urandom_range(99) < 60) ? 6'($urandom_range(7)) : 6'($urandom);
    r.col = 6'($urandom);
    r.value = random_q();
    r.noise = random_q();
    return r;
  endfunction

  task automatic push_request(hopf_pkg::mode_t mode, int row, int col, int value, int noise);
    request_t r;
    r.mode = mode;
    r.row = 6'(row);
    r.col = 6'(col);
    r.value = 16'(value);
    r.noise = 16'(noise);
    requests_pending.push_back(r);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [14:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      hopf_pkg::REG_STEP_SIZE: step_size_q = data;
      hopf_pkg::REG_NOISE_LIMIT: noise_limit_q = data;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (requests_pending.size() != 0 || in_valid || results_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (NEURONS + 8) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        results_due.push_back(predict_neuron_result(offered));
        mode_count[offered.mode]++;
      end
      if (!in_valid || !in_stall) begin
        if (requests_pending.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered = requests_pending.pop_front();
          in_valid <= 1'b1;
          in_mode <= offered.mode;
          in_row_index <= offered.row;
          in_col_index <= offered.col;
          in_value <= offered.value;
          in_noise <= offered.noise;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{out_neuron_index, out_new_state, out_weight_read, out_field_positive};
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t unexpected result: neuron %0d state %0d weight %0d field %0d",
                   $time, seen.neuron, seen.state, seen.wread, seen.fpos);
        end else begin
          want = results_due.pop_front();
          checked++;
          if (want.fpos) positive_fields++;
          if (seen !== want) begin
            errors++;
            // neuron / state / weight / field
            $display("%0t mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
                     $time, want.neuron, want.state, want.wread, want.fpos,
                     seen.neuron, seen.state, seen.wread, seen.fpos);
          end
        end
      end
      out_stall <= holding_off || ($urandom_range(99) < rx_stall_pct);
    end
  end

  // long receiver hold-off so that the engine backs up and stalls its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    holding_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding_off <= 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero field, raw weight extremes, state clamps, noise bound of zero
    push_request(hopf_pkg::MODE_UPDATE, 0, 0, 0, 0);
    push_request(hopf_pkg::MODE_RD_WEIGHT, 0, 0, 0, 0);
    push_request(hopf_pkg::MODE_WR_WEIGHT, 63, 63, 32767, 0);
    push_request(hopf_pkg::MODE_RD_WEIGHT, 63, 63, 0, 0);
    push_request(hopf_pkg::MODE_WR_WEIGHT, 0, 63, -32768, 0);
    push_request(hopf_pkg::MODE_WR_STATE, 63, 0, 32767, 0);
    push_request(hopf_pkg::MODE_WR_STATE, 0, 0, -32768, 0);
    push_request(hopf_pkg::MODE_UPDATE, 63, 0, 0, 16384);
    push_request(hopf_pkg::MODE_UPDATE, 0, 0, 0, -16384);
    push_request(hopf_pkg::MODE_WR_STATE, 5, 0, 16385, 0);
    push_request(hopf_pkg::MODE_WR_STATE, 6, 0, -16385, 0);
    push_request(hopf_pkg::MODE_WR_STATE, 7, 0, -1, 0);
    // weighted sum that cancels exactly to zero
    push_request(hopf_pkg::MODE_WR_WEIGHT, 2, 0, 16384, 0);
    push_request(hopf_pkg::MODE_WR_WEIGHT, 2, 1, 16384, 0);
    push_request(hopf_pkg::MODE_WR_STATE, 0, 0, 16384, 0);
    push_request(hopf_pkg::MODE_WR_STATE, 1, 0, -16384, 0);
    push_request(hopf_pkg::MODE_UPDATE, 2, 0, 0, 0);
    push_request(hopf_pkg::MODE_RD_WEIGHT, 2, 1, 0, 0);
    push_request(hopf_pkg::MODE_WR_WEIGHT, 42, 21, 21845, 0);
    push_request(hopf_pkg::MODE_RD_WEIGHT, 42, 21, 0, 0);
    push_request(hopf_pkg::MODE_RD_WEIGHT, 21, 42, 0, 0);
    push_request(hopf_pkg::MODE_UPDATE, 21, 0, 0, 32767);
    push_request(hopf_pkg::MODE_UPDATE, 63, 0, -21846, -32768);
    wait_drained();

    for (int p = 0; p < 5; p++) begin
      if (p == 4) begin
        step_set[p] = $urandom_range(32767);
        noise_set[p] = $urandom_range(16384);
      end
      write_reg(hopf_pkg::REG_STEP_SIZE, 15'(step_set[p]));
      write_reg(hopf_pkg::REG_NOISE_LIMIT, 15'(noise_set[p]));
      if (p == 1) write_reg(REG_UNUSED, 15'h7fff);
      sender_idle_pct = idle_set[p];
      rx_stall_pct = stall_set[p];
      repeat (PHASE_REQUESTS) requests_pending.push_back(random_request());
      if (p == 4) pressure_go = 1'b1;
      wait_drained();
    end

    $display("checked %0d results over six register settings and four idling patterns",
             checked);
    $display("%0d updates (%0d positive field), %0d weight writes, %0d state writes, %0d reads",
             mode_count[hopf_pkg::MODE_UPDATE], positive_fields,
             mode_count[hopf_pkg::MODE_WR_WEIGHT], mode_count[hopf_pkg::MODE_WR_STATE],
             mode_count[hopf_pkg::MODE_RD_WEIGHT]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
